// ===== rtl/core/prgd_pkg.sv =====
// prgd_pkg: shared types, widths and helpers of the polynomial regression trainer
// no dependencies; used by the interfaces, the shared units and the top level
package prgd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned LR_W    = 16;
  localparam int unsigned ITER_W  = 20;
  localparam int unsigned CFG_A_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_DEGREE    = 2'd0,
    CFG_LRATE     = 2'd1,
    CFG_TOLERANCE = 2'd2,
    CFG_MAX_ITER  = 2'd3
  } cfg_idx_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

  // clamp a wide signed value to the signed word range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -PROD_W'(64'sh0000_0000_8000_0000);
    if (v > hi) begin
      return DATA_W'(32'h7FFF_FFFF);
    end else if (v < lo) begin
      return DATA_W'(32'h8000_0000);
    end
    return v[DATA_W-1:0];
  endfunction

  // q16.16 product back to a wide signed value, floor rounding
  function automatic logic signed [PROD_W-1:0] qshift(input logic signed [PROD_W-1:0] p);
    return {{16{p[PROD_W-1]}}, p[PROD_W-1:16]};
  endfunction

endpackage

// ===== rtl/core/prgd_in_if.sv =====
// prgd_in_if: sample channel, one (x, y, last) word per handshake
// depends on prgd_pkg
interface prgd_in_if import prgd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;
  logic                     last;

  modport source (output valid, output x_value, output y_value, output last, input ready);
  modport sink (input valid, input x_value, input y_value, input last, output ready);
endinterface

// ===== rtl/core/prgd_out_if.sv =====
// prgd_out_if: coefficient channel, one trained coefficient word per handshake
// depends on prgd_pkg
interface prgd_out_if import prgd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         coeff_index;
  logic signed [DATA_W-1:0] coeff_value;
  logic [DATA_W-1:0]        final_loss;
  logic [ITER_W-1:0]        iterations_done;
  logic                     end_of_run;

  modport source (output valid, output coeff_index, output coeff_value, output final_loss,
                  output iterations_done, output end_of_run, input ready);
  modport sink (input valid, input coeff_index, input coeff_value, input final_loss,
                input iterations_done, input end_of_run, output ready);
endinterface

// ===== rtl/core/prgd_cfg_if.sv =====
// prgd_cfg_if: configuration write channel, register index and data
// depends on prgd_pkg
interface prgd_cfg_if import prgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/prgd_mul.sv =====
// prgd_mul: shared signed 32x32 multiplier with registered product
// depends on prgd_pkg
module prgd_mul import prgd_pkg::*; (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // product lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/prgd_div.sv =====
// prgd_div: restoring divider, 64-bit magnitude by the sample count, one bit a cycle
// depends on prgd_pkg
module prgd_div import prgd_pkg::*; #(
  parameter int unsigned CNT_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [CNT_W-1:0] divisor,
  output div_rsp_t         rsp
);

  localparam int unsigned STEP_W = $clog2(PROD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [PROD_W-1:0] quot_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_r, quot_r[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(PROD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.mag;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[PROD_W-2:0], fits};
      rem_r  <= fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/core/polynomial_regression_gd_trainer.sv =====
// polynomial_regression_gd_trainer: sample store, training sequencer and output register
// depends on prgd_pkg, the prgd channel interfaces, prgd_mul and prgd_div
//
// Samples are taken one word per cycle into on-chip stores until a word marked last.
// Training then runs by batch gradient descent on x^1..degree with a single shared
// 32x32 multiplier and a bit-serial divider; the block takes no sample meanwhile.
// One descent iteration is a pass over the samples, then the loss division, then one
// divide and update per coefficient (degree + 1 of them). The bias and then each
// weight leave as one word each, the last one flagged end_of_run. Weights and bias
// persist across runs.
module polynomial_regression_gd_trainer import prgd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned MAX_DEGREE  = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  prgd_in_if.sink     in_chan,
  prgd_out_if.source  out_chan,
  prgd_cfg_if.sink    cfg_chan
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int unsigned K_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  typedef enum logic [20:0] {
    S_LOAD = 21'h000001, S_CLR  = 21'h000002, S_RD   = 21'h000004,
    S_RDW  = 21'h000008, S_PW   = 21'h000010, S_PWA  = 21'h000020,
    S_PF   = 21'h000040, S_PFA  = 21'h000080, S_RES  = 21'h000100,
    S_SQ   = 21'h000200, S_SQA  = 21'h000400, S_GM   = 21'h000800,
    S_GMA  = 21'h001000, S_LDIV = 21'h002000, S_LDW  = 21'h004000,
    S_GDIV = 21'h008000, S_GDW  = 21'h010000, S_UM   = 21'h020000,
    S_UMA  = 21'h040000, S_OUT  = 21'h080000, S_OWT  = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [3:0]        degree_r;
  logic [LR_W-1:0]   lrate_r;
  logic [DATA_W-1:0] tol_r;
  logic [ITER_W-1:0] maxit_r;

  // sample stores
  logic signed [DATA_W-1:0] x_mem [MAX_SAMPLES];
  logic signed [DATA_W-1:0] y_mem [MAX_SAMPLES];
  logic signed [DATA_W-1:0] x_rd_r, y_rd_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         i_r;

  // model state
  logic signed [DATA_W-1:0] w_r [MAX_DEGREE];
  logic signed [DATA_W-1:0] bias_r;

  // training datapath
  logic [DEG_W-1:0]         deg_r;
  logic [K_W-1:0]           deg_m1_r;
  logic [K_W-1:0]           k_r;
  logic [DEG_W-1:0]         j_r;
  logic signed [DATA_W-1:0] x_r, y_r, f_r, e_r, g_r;
  logic signed [DATA_W-1:0] feat_r [MAX_DEGREE];
  logic signed [PROD_W-1:0] pred_r;
  logic [PROD_W-1:0]        lsum_r;
  logic signed [PROD_W-1:0] gb_r;
  logic signed [PROD_W-1:0] gw_r [MAX_DEGREE];
  logic                     gneg_r;
  logic [DATA_W-1:0]        loss_r, old_r;
  logic [ITER_W-1:0]        iter_r;

  // output register
  logic                     ovalid_r;
  logic [IDX_W-1:0]         oidx_r;
  logic signed [DATA_W-1:0] oval_r;
  logic [DATA_W-1:0]        oloss_r;
  logic [ITER_W-1:0]        oiter_r;
  logic                     oeor_r;

  // shared units
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  logic                     in_acc, cfg_acc;
  logic [DEG_W-1:0]         deg_clamp;
  logic [DATA_W-1:0]        loss_new, diff;
  logic                     go_on;
  logic signed [PROD_W-1:0] gsel;
  logic signed [DATA_W-1:0] cur_coef;
  logic signed [DATA_W-1:0] new_coef;
  logic signed [PROD_W-1:0] quot_s;
  logic                     at_bias;

  prgd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  prgd_div #(.CNT_W(CNT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dreq),
    .divisor (cnt_r),
    .rsp     (drsp)
  );

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == S_LOAD);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid           = ovalid_r;
  assign out_chan.coeff_index     = oidx_r;
  assign out_chan.coeff_value     = oval_r;
  assign out_chan.final_loss      = oloss_r;
  assign out_chan.iterations_done = oiter_r;
  assign out_chan.end_of_run      = oeor_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 4'd1;
      lrate_r  <= LR_W'(655);
      tol_r    <= DATA_W'(66);
      maxit_r  <= ITER_W'(1000);
    end else if (cfg_acc) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_DEGREE:    degree_r <= cfg_chan.data[3:0];
        CFG_LRATE:     lrate_r  <= cfg_chan.data[LR_W-1:0];
        CFG_TOLERANCE: tol_r    <= cfg_chan.data;
        CFG_MAX_ITER:  maxit_r  <= cfg_chan.data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store write and registered read
  always_ff @(posedge clk) begin
    if (in_acc && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
      x_mem[cnt_r[ADR_W-1:0]] <= in_chan.x_value;
      y_mem[cnt_r[ADR_W-1:0]] <= in_chan.y_value;
    end
    x_rd_r <= x_mem[i_r[ADR_W-1:0]];
    y_rd_r <= y_mem[i_r[ADR_W-1:0]];
  end

  // degree clamped to the supported range
  always_comb begin
    if (degree_r == 4'd0) begin
      deg_clamp = DEG_W'(1);
    end else if (32'(degree_r) > MAX_DEGREE) begin
      deg_clamp = DEG_W'(MAX_DEGREE);
    end else begin
      deg_clamp = DEG_W'(degree_r);
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = f_r;
    mul_b = x_r;
    unique case (state_r)
      S_PW: begin mul_a = w_r[k_r]; mul_b = f_r; end
      S_SQ: begin mul_a = e_r; mul_b = e_r; end
      S_GM: begin mul_a = e_r; mul_b = feat_r[k_r]; end
      S_UM: begin mul_a = DATA_W'(lrate_r); mul_b = g_r; end
      default: ;
    endcase
  end

  // divider request and loss / gradient decode
  assign at_bias  = (j_r == deg_r);
  assign gsel     = at_bias ? gb_r : gw_r[j_r[K_W-1:0]];
  assign loss_new = (drsp.quot > PROD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                         : drsp.quot[DATA_W-1:0];
  assign diff     = (loss_new > old_r) ? (loss_new - old_r) : (old_r - loss_new);
  assign go_on    = (diff > tol_r) && (iter_r < maxit_r);
  assign quot_s   = gneg_r ? -$signed(drsp.quot) : $signed(drsp.quot);
  assign cur_coef = at_bias ? bias_r : w_r[j_r[K_W-1:0]];
  assign new_coef = sat32(PROD_W'(cur_coef) - qshift(prod));

  always_comb begin
    dreq.start = 1'b0;
    dreq.mag   = lsum_r;
    if (state_r == S_LDIV) begin
      dreq.start = 1'b1;
    end else if (state_r == S_GDIV) begin
      dreq.start = 1'b1;
      dreq.mag   = gsel[PROD_W-1] ? PROD_W'(-gsel) : PROD_W'(gsel);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (in_acc && in_chan.last) state_nxt = S_CLR;
      S_CLR:  state_nxt = S_RD;
      S_RD:   state_nxt = S_RDW;
      S_RDW:  state_nxt = S_PW;
      S_PW:   state_nxt = S_PWA;
      S_PWA:  state_nxt = (k_r == deg_m1_r) ? S_RES : S_PF;
      S_PF:   state_nxt = S_PFA;
      S_PFA:  state_nxt = S_PW;
      S_RES:  state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQA;
      S_SQA:  state_nxt = S_GM;
      S_GM:   state_nxt = S_GMA;
      S_GMA: begin
        if (k_r != deg_m1_r) begin
          state_nxt = S_GM;
        end else if (i_r == cnt_r - 1'b1) begin
          state_nxt = S_LDIV;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_LDIV: state_nxt = S_LDW;
      S_LDW:  if (drsp.done) state_nxt = go_on ? S_GDIV : S_OUT;
      S_GDIV: state_nxt = S_GDW;
      S_GDW:  if (drsp.done) state_nxt = S_UM;
      S_UM:   state_nxt = S_UMA;
      S_UMA:  state_nxt = at_bias ? S_CLR : S_GDIV;
      S_OUT:  state_nxt = S_OWT;
      S_OWT:  if (out_chan.ready) state_nxt = at_bias ? S_LOAD : S_OUT;
      default: state_nxt = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      bias_r   <= '0;
      for (int m = 0; m < MAX_DEGREE; m++) begin
        w_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_OUT) begin
        ovalid_r <= 1'b1;
      end
      if ((state_r == S_OWT) && out_chan.ready) begin
        ovalid_r <= 1'b0;
        if (at_bias) begin
          cnt_r <= '0;
        end
      end
      // coefficient update
      if (state_r == S_UMA) begin
        if (at_bias) begin
          bias_r <= new_coef;
        end else begin
          w_r[j_r[K_W-1:0]] <= new_coef;
        end
      end
    end
  end

  // training datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        deg_r    <= deg_clamp;
        deg_m1_r <= K_W'(deg_clamp - 1'b1);
        old_r    <= '0;
        iter_r   <= '0;
      end
      S_CLR: begin
        i_r    <= '0;
        lsum_r <= '0;
        gb_r   <= '0;
        for (int m = 0; m < MAX_DEGREE; m++) begin
          gw_r[m] <= '0;
        end
      end
      S_RDW: begin
        x_r    <= x_rd_r;
        y_r    <= y_rd_r;
        f_r    <= x_rd_r;
        pred_r <= PROD_W'(bias_r);
        k_r    <= '0;
      end
      S_PW:  feat_r[k_r] <= f_r;
      S_PWA: pred_r <= pred_r + qshift(prod);
      S_PFA: begin
        f_r <= sat32(qshift(prod));
        k_r <= k_r + 1'b1;
      end
      S_RES: begin
        e_r <= sat32(PROD_W'(sat32(pred_r)) - PROD_W'(y_r));
        k_r <= '0;
      end
      S_SQA: begin
        lsum_r <= lsum_r + {16'd0, prod[PROD_W-1:16]};
        gb_r   <= gb_r + PROD_W'(e_r);
      end
      S_GMA: begin
        gw_r[k_r] <= gw_r[k_r] + qshift(prod);
        if (k_r != deg_m1_r) begin
          k_r <= k_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      S_LDW: begin
        if (drsp.done) begin
          loss_r <= loss_new;
          j_r    <= '0;
        end
      end
      S_GDIV: gneg_r <= gsel[PROD_W-1];
      S_GDW:  if (drsp.done) g_r <= sat32(quot_s);
      S_UMA: begin
        if (at_bias) begin
          old_r  <= loss_r;
          iter_r <= iter_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      // word j carries the bias first, then the weight of x^j
      S_OUT: begin
        oidx_r  <= IDX_W'(j_r);
        oval_r  <= (j_r == '0) ? bias_r : w_r[K_W'(j_r - 1'b1)];
        oloss_r <= loss_r;
        oiter_r <= iter_r;
        oeor_r  <= at_bias;
      end
      S_OWT: if (out_chan.ready && !at_bias) j_r <= j_r + 1'b1;
      default: ;
    endcase
  end

  // a coefficient word is offered only while the sequencer waits for it
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (state_r == S_OWT))
    else $error("coefficient word offered outside the output wait");

  // the sample count never runs past the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // a taken coefficient word moves on to the next one or back to loading
  a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OWT && out_chan.ready) |=> (state_r == S_OUT || state_r == S_LOAD))
    else $error("sequencer lost its place after a coefficient word");

  // the divider reports done only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_LDW || state_r == S_GDW))
    else $error("divider result with no one waiting");

endmodule

// ===== test/polynomial_regression_gd_trainer_tb.sv =====
`timescale 1ns / 1ps
// polynomial_regression_gd_trainer_tb: self-checking bench for the gradient descent trainer
// depends on prgd_pkg, the prgd channel interfaces and polynomial_regression_gd_trainer
module polynomial_regression_gd_trainer_tb;
  import prgd_pkg::*;

  localparam int unsigned SAMPLE_DEPTH = 1024;
  localparam int unsigned DEGREE_CAP   = 8;
  localparam int unsigned STALL_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct {
    logic [IDX_W-1:0]  coeff_index;
    logic [31:0]       coeff_value;
    logic [31:0]       final_loss;
    logic [ITER_W-1:0] iterations_done;
    logic              end_of_run;
  } coeff_word_t;

  // trainer predictor and store of expected coefficient words
  class coeff_board;
    logic [3:0]  degree_reg;
    logic [15:0] rate_reg;
    logic [31:0] tol_reg;
    logic [19:0] iter_limit_reg;
    int          x_mem[SAMPLE_DEPTH];
    int          y_mem[SAMPLE_DEPTH];
    int          feat[SAMPLE_DEPTH][DEGREE_CAP];
    int unsigned held;
    int          weights[DEGREE_CAP];
    int          bias;
    coeff_word_t expected_coeffs[$];
    int          fails;

    function new();
      degree_reg     = 4'd1;
      rate_reg       = 16'd655;
      tol_reg        = 32'd66;
      iter_limit_reg = 20'd1000;
      held           = 0;
      bias           = 0;
      fails          = 0;
      foreach (weights[k]) weights[k] = 0;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_DEGREE:    degree_reg = data[3:0];
        CFG_LRATE:     rate_reg = data[15:0];
        CFG_TOLERANCE: tol_reg = data;
        CFG_MAX_ITER:  iter_limit_reg = data[19:0];
        default: ;
      endcase
    endfunction

    // prediction minus target for one sample
    function int fit_error(int i, int d);
      longint p;
      p = bias;
      for (int k = 0; k < d; k++) p += (longint'(weights[k]) * feat[i][k]) >>> 16;
      return clamp32(longint'(clamp32(p)) - y_mem[i]);
    endfunction

    function logic [31:0] mean_sq(int d);
      longint unsigned sum;
      longint unsigned q;
      longint e;
      sum = 0;
      for (int i = 0; i < held; i++) begin
        e = fit_error(i, d);
        sum += longint'((e * e) >>> 16);
      end
      q = sum / held;
      return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function void descend_once(int d);
      longint gw[DEGREE_CAP];
      longint gb;
      longint e;
      longint g;
      gb = 0;
      foreach (gw[k]) gw[k] = 0;
      for (int i = 0; i < held; i++) begin
        e = fit_error(i, d);
        gb += e;
        for (int k = 0; k < d; k++) gw[k] += (e * feat[i][k]) >>> 16;
      end
      for (int k = 0; k < d; k++) begin
        g = clamp32(gw[k] / longint'(held));
        weights[k] = clamp32(longint'(weights[k]) - ((longint'(rate_reg) * g) >>> 16));
      end
      g = clamp32(gb / longint'(held));
      bias = clamp32(longint'(bias) - ((longint'(rate_reg) * g) >>> 16));
    endfunction

    // accepted sample: store it, and on the last mark train and queue the coefficients
    function void note_sample(int x, int y, bit last);
      int          d;
      int          p;
      logic [31:0] loss;
      logic [31:0] prev_loss;
      logic [31:0] diff;
      int unsigned iter;
      coeff_word_t w;
      if (held < SAMPLE_DEPTH) begin
        x_mem[held] = x;
        y_mem[held] = y;
        held++;
      end
      if (!last) return;
      d = (degree_reg == 0) ? 1 : ((degree_reg > DEGREE_CAP) ? DEGREE_CAP : degree_reg);
      for (int i = 0; i < held; i++) begin
        p = x_mem[i];
        feat[i][0] = p;
        for (int k = 1; k < d; k++) begin
          p = clamp32((longint'(p) * x_mem[i]) >>> 16);
          feat[i][k] = p;
        end
      end
      prev_loss = 0;
      loss = mean_sq(d);
      iter = 0;
      forever begin
        diff = (loss > prev_loss) ? loss - prev_loss : prev_loss - loss;
        if (!(diff > tol_reg && iter < iter_limit_reg)) break;
        descend_once(d);
        prev_loss = loss;
        loss = mean_sq(d);
        iter++;
      end
      held = 0;
      for (int k = 0; k <= d; k++) begin
        w.coeff_index     = k[IDX_W-1:0];
        w.coeff_value     = (k == 0) ? bias : weights[k-1];
        w.final_loss      = loss;
        w.iterations_done = iter[ITER_W-1:0];
        w.end_of_run      = (k == d);
        expected_coeffs.push_back(w);
      end
    endfunction

    function void check_coeff(coeff_word_t got);
      coeff_word_t want;
      if (expected_coeffs.size() == 0) begin
        $error("coefficient word with none expected: index %0d", got.coeff_index);
        fails++;
        return;
      end
      want = expected_coeffs.pop_front();
      if (got.coeff_index !== want.coeff_index) begin
        $error("coeff_index: expected %0d, got %0d", want.coeff_index, got.coeff_index);
        fails++;
      end
      if (got.coeff_value !== want.coeff_value) begin
        $error("coeff_value: expected %h, got %h", want.coeff_value, got.coeff_value);
        fails++;
      end
      if (got.final_loss !== want.final_loss) begin
        $error("final_loss: expected %h, got %h", want.final_loss, got.final_loss);
        fails++;
      end
      if (got.iterations_done !== want.iterations_done) begin
        $error("iterations_done: expected %0d, got %0d", want.iterations_done,
               got.iterations_done);
        fails++;
      end
      if (got.end_of_run !== want.end_of_run) begin
        $error("end_of_run: expected %b, got %b", want.end_of_run, got.end_of_run);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  prgd_in_if  in_if();
  prgd_out_if out_if();
  prgd_cfg_if cfg_if();

  coeff_board  board = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          long_hold;
  int unsigned hold_count;
  int unsigned quiet_cycles;

  polynomial_regression_gd_trainer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold) begin
      out_if.ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        long_hold = 1'b0;
        hold_count = 0;
      end
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    coeff_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.coeff_index     = out_if.coeff_index;
      got.coeff_value     = out_if.coeff_value;
      got.final_loss      = out_if.final_loss;
      got.iterations_done = out_if.iterations_done;
      got.end_of_run      = out_if.end_of_run;
      board.check_coeff(got);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves cfg valid high; setup drops it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_reg(idx, data);
  endtask

  task automatic setup(logic [3:0] deg, logic [15:0] rate, logic [31:0] tol,
                       logic [19:0] iter_limit);
    write_reg(CFG_DEGREE, 32'(deg));
    write_reg(CFG_LRATE, 32'(rate));
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, 32'(iter_limit));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] x, logic [31:0] y, bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.x_value <= x;
    in_if.y_value <= y;
    in_if.last    <= last;
    do @(posedge clk); while (!in_if.ready);
    board.note_sample(int'(x), int'(y), last);
  endtask

  // sender waits until every coefficient word has arrived and the block is idle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.expected_coeffs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  task automatic random_sets(int unsigned count);
    int unsigned left;
    int unsigned len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 10);
      if (len > left) len = left;
      for (int unsigned i = 0; i < len; i++) send_sample(pick_value(), pick_value(), i == len - 1);
      left -= len;
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.x_value  <= '0;
    in_if.y_value  <= '0;
    in_if.last     <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_DEGREE;
    cfg_if.data    <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold      = 1'b0;
    hold_count     = 0;
    quiet_cycles   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes at full degree and full rate, zero tolerance
    setup(4'd8, 16'hFFFF, 32'h0, 20'd3);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_sample(32'h0, 32'h0, 1'b0);
    send_sample(32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_0000, 32'h0000_0001, 1'b1);
    drain();
    // degree zero, zero rate, single-sample set
    setup(4'd0, 16'h0, 32'd66, 20'd2);
    send_sample(32'h0002_0000, 32'h0003_0000, 1'b1);
    drain();
    // degree above the cap, weights carried over
    setup(4'd15, 16'd1000, 32'h0, 20'd4);
    send_sample(32'h0000_8000, 32'h0001_0000, 1'b0);
    send_sample(32'hFFFF_8000, 32'h0002_0000, 1'b0);
    send_sample(32'h0001_8000, 32'hFFFE_0000, 1'b0);
    send_sample(32'h0000_4000, 32'h0000_0000, 1'b1);
    drain();
    // highest iteration limit with widest tolerance, then zero iterations
    setup(4'd5, 16'd655, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_sample(32'h0001_0000, 32'h0004_0000, 1'b0);
    send_sample(32'h0002_0000, 32'h0001_0000, 1'b1);
    drain();
    setup(4'd2, 16'd3000, 32'h0, 20'd0);
    send_sample(32'h0003_0000, 32'h0005_0000, 1'b1);
    drain();

    // random phases under the four idling patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      setup(4'($urandom_range(0, 15)), 16'($urandom), $urandom_range(0, 3) == 0 ? $urandom :
            32'($urandom_range(0, 4096)), 20'($urandom_range(0, 12)));
      // block fills up and stalls its input behind a held-off receiver
      if (phase == 0) long_hold = 1'b1;
      random_sets(50);
      drain();
    end
    repeat (100) @(posedge clk);

    if (board.fails == 0 && board.expected_coeffs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prgd_pkg.sv
rtl/core/prgd_in_if.sv
rtl/core/prgd_out_if.sv
rtl/core/prgd_cfg_if.sv
rtl/core/prgd_mul.sv
rtl/core/prgd_div.sv
rtl/core/polynomial_regression_gd_trainer.sv
test/polynomial_regression_gd_trainer_tb.sv
